@@ design/tap_tempo_estimator_assert.svh @@
// Assertion macros for the tap-tempo estimator.
// Used by the top level; each macro expects clk and rst_n in scope.
`ifndef TAP_TEMPO_ESTIMATOR_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tte_pkg.sv @@
// Package for the tap-tempo estimator: item structures, field widths and codes.
// No dependencies; used by tte_serial_div, the top level and the bench.
`default_nettype none

package tte_pkg;

  localparam int NOW_W      = 32;
  localparam int BPM_W      = 23;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;
  // 60000 ms per minute, in hundredths of a beat.
  localparam logic [BPM_W-1:0]     BPM_NUMERATOR = 23'd6000000;

  localparam logic OP_TAP   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ENABLE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TIMEOUT = 1'd1;

  typedef struct packed {
    logic             operation;
    logic [NOW_W-1:0] now_ms;
  } tte_in_t;

  typedef struct packed {
    logic             bpm_ready;
    logic [BPM_W-1:0] bpm_x100;
    logic [1:0]       taps_in_run;
    logic             timed_out;
  } tte_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tte_div_stat_t;

endpackage

`default_nettype wire

@@ design/tte_stream_if.sv @@
// Valid/ready stream interface carrying one payload structure per transfer.
// The payload type is chosen at instantiation from tte_pkg.
`default_nettype none

interface tte_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tte_serial_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle through shift registers.
// Depends on tte_pkg for the status structure.
`default_nettype none

module tte_serial_div
  import tte_pkg::*;
#(
  parameter int W      = 34,
  parameter int STEP_W = $clog2(W + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] step_cnt,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  output tte_div_stat_t          stat,
  output logic      [W-1:0]      quotient
);

  logic [W-1:0]      rem_r, rem_nxt;
  logic [W-1:0]      quo_r, quo_nxt;
  logic [W-1:0]      div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [W:0]        trial;
  logic [W:0]        diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = step_cnt;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

@@ design/tap_tempo_estimator.sv @@
// Tap-tempo estimator top level: run tracking, sequencing and the result register.
// Depends on tte_pkg, tte_stream_if, tte_serial_div and the assertion macro header.
//
// Usage: items arrive on in_ch (a tap or a time check with a millisecond stamp) and
// exactly one result leaves on out_ch per item, in order. Each channel moves an
// item on a transfer, at a rising edge where valid and ready are both high. The
// configuration port writes the enable bit (index 0) or the timeout (index 1)
// whenever cfg_we is high; it is meant to be written while the block is idle.
// One item is worked on at a time. A time check, an ignored tap or a tap that
// does not finish a run passes through the result register into the output
// register once that is free, and in_ch is ready again in that same cycle. A tap
// that finishes a run runs the serial divider twice, one quotient bit per cycle:
// first on the interval sum for the average interval, then on the numerator for
// the estimate, which then passes through the result register in the same way.
// A zero average skips the second division.
// A synchronous active-low reset clears the run, restores the enable to 0 and
// the timeout to 3000 ms, and empties the output register. While out_ch is
// stalled a finished result waits in the output register; the next item is
// still taken, and its own result waits until the register is free.
`default_nettype none
`include "tap_tempo_estimator_assert.svh"

module tap_tempo_estimator
  import tte_pkg::*;
#(
  parameter int TAPS_PER_ESTIMATE = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tte_stream_if.sink                 in_ch,
  tte_stream_if.source               out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W     = $clog2(TAPS_PER_ESTIMATE + 1);
  localparam int SUM_W     = NOW_W + $clog2(TAPS_PER_ESTIMATE);
  localparam int STEP_W    = $clog2(SUM_W + 1);
  localparam int INTERVALS = TAPS_PER_ESTIMATE - 1;

  typedef enum logic [1:0] {S_IDLE, S_AVG, S_BPM, S_LOAD} state_t;

  state_t               state_r, state_nxt;
  logic                 enable_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [CNT_W-1:0]     tap_cnt_r, tap_cnt_nxt;
  logic [NOW_W-1:0]     last_tap_r, last_tap_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  tte_out_t             res_r, res_nxt;
  tte_out_t             out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 in_fire;
  logic [NOW_W-1:0]     elapsed;
  logic [CNT_W-1:0]     cnt_inc;
  logic [SUM_W-1:0]     sum_add;

  logic                 div_start;
  logic [STEP_W-1:0]    div_steps;
  logic [SUM_W-1:0]     div_dividend;
  logic [SUM_W-1:0]     div_divisor;
  tte_div_stat_t        div_stat;
  logic [SUM_W-1:0]     div_quotient;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign elapsed = in_ch.data.now_ms - last_tap_r;
  assign cnt_inc = tap_cnt_r + CNT_W'(1);
  assign sum_add = (tap_cnt_r != '0) ? sum_r + SUM_W'(elapsed) : sum_r;

  always_comb begin
    state_nxt     = state_r;
    tap_cnt_nxt   = tap_cnt_r;
    last_tap_nxt  = last_tap_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_steps     = STEP_W'(SUM_W);
    div_dividend  = sum_add;
    div_divisor   = SUM_W'(INTERVALS);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt             = '0;
          res_nxt.taps_in_run = tap_cnt_r[1:0];
          state_nxt           = S_LOAD;
          if (in_ch.data.operation == OP_TAP) begin
            if (enable_r) begin
              last_tap_nxt = in_ch.data.now_ms;
              if (cnt_inc == CNT_W'(TAPS_PER_ESTIMATE)) begin
                tap_cnt_nxt         = '0;
                sum_nxt             = '0;
                res_nxt.bpm_ready   = 1'b1;
                res_nxt.taps_in_run = 2'd0;
                div_start           = 1'b1;
                state_nxt           = S_AVG;
              end else begin
                tap_cnt_nxt         = cnt_inc;
                sum_nxt             = sum_add;
                res_nxt.taps_in_run = cnt_inc[1:0];
              end
            end
          end else if (tap_cnt_r != '0 && elapsed > NOW_W'(timeout_r)) begin
            tap_cnt_nxt         = '0;
            sum_nxt             = '0;
            res_nxt.timed_out   = 1'b1;
            res_nxt.taps_in_run = 2'd0;
          end
        end
      end
      S_AVG: begin
        if (div_stat.done) begin
          if (div_quotient == '0) begin
            res_nxt.bpm_x100 = BPM_NUMERATOR;
            state_nxt        = S_LOAD;
          end else begin
            div_start    = 1'b1;
            div_steps    = STEP_W'(BPM_W);
            div_dividend = {BPM_NUMERATOR, {(SUM_W - BPM_W){1'b0}}};
            div_divisor  = div_quotient;
            state_nxt    = S_BPM;
          end
        end
      end
      S_BPM: begin
        if (div_stat.done) begin
          res_nxt.bpm_x100 = div_quotient[BPM_W-1:0];
          state_nxt        = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      tap_cnt_r   <= '0;
      last_tap_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      last_tap_r  <= last_tap_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == CFG_IDX_ENABLE) begin
        enable_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_addr == CFG_IDX_TIMEOUT) begin
        timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
      end
    end
  end

  tte_serial_div #(
    .W      (SUM_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .step_cnt (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `TTE_ASSERT_NEXT(a_fire_leaves_idle, in_fire, state_r != S_IDLE,
    "An accepted item did not start processing.")
  `TTE_ASSERT_NOW(a_estimate_ends_run, out_valid_r && out_data_r.bpm_ready,
    !out_data_r.timed_out && out_data_r.taps_in_run == 2'd0,
    "An estimate result did not report an ended run.")
  `TTE_ASSERT_NOW(a_bpm_only_with_ready, out_valid_r && !out_data_r.bpm_ready,
    out_data_r.bpm_x100 == '0, "A tempo value was reported without an estimate.")
  `TTE_ASSERT_NOW(a_div_only_in_estimate, div_stat.busy,
    state_r == S_AVG || state_r == S_BPM, "The divider ran outside an estimate.")

endmodule

`default_nettype wire

@@ bench/tap_tempo_estimator_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the tap-tempo estimator: directed and random taps and time checks
// against a tempo predictor, with sender gaps, receiver stalls and a long output hold-off.
// Depends on tte_pkg, tte_stream_if and the tap_tempo_estimator design files.

module tap_tempo_estimator_test
  import tte_pkg::*;
();

  localparam int          TAPS_PER_RUN  = 4;
  localparam logic [63:0] BPM_SCALE     = 64'd6000000;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          ITEMS_PER_PHASE = 100;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} rx_flow_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tte_stream_if #(.data_t(tte_in_t))  in_ch ();
  tte_stream_if #(.data_t(tte_out_t)) out_ch ();

  tap_tempo_estimator #(
    .TAPS_PER_ESTIMATE(TAPS_PER_RUN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the configuration and of the current run.
  logic        taps_enabled;
  logic [15:0] timeout_limit;
  int unsigned run_taps;
  logic [31:0] run_last_tap;
  logic [63:0] run_interval_sum;

  tte_out_t    expected_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned hold_off_left;
  int unsigned burst_left;
  logic [31:0] stamp_ms;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic tte_out_t predict_tempo(input logic op, input logic [31:0] now);
    tte_out_t    res;
    logic [31:0] elapsed;
    logic [63:0] avg;
    res     = '0;
    elapsed = now - run_last_tap;
    if (op == OP_TAP) begin
      if (taps_enabled) begin
        run_taps++;
        if (run_taps > 1) run_interval_sum += {32'd0, elapsed};
        run_last_tap = now;
        if (run_taps >= TAPS_PER_RUN) begin
          avg = run_interval_sum / 64'(TAPS_PER_RUN - 1);
          res.bpm_x100  = (avg == 0) ? BPM_SCALE[BPM_W-1:0] : BPM_W'(BPM_SCALE / avg);
          res.bpm_ready = 1'b1;
          run_taps         = 0;
          run_interval_sum = '0;
        end
      end
    end else if (run_taps > 0 && elapsed > {16'd0, timeout_limit}) begin
      run_taps         = 0;
      run_interval_sum = '0;
      res.timed_out    = 1'b1;
    end
    res.taps_in_run = run_taps[1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void expect_result(input tte_out_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  always @(posedge clk) begin
    tte_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("bpm_ready", 32'(want.bpm_ready), 32'(out_ch.data.bpm_ready));
        check_field("bpm_x100", 32'(want.bpm_x100), 32'(out_ch.data.bpm_x100));
        check_field("taps_in_run", 32'(want.taps_in_run), 32'(out_ch.data.taps_in_run));
        check_field("timed_out", 32'(want.timed_out), 32'(out_ch.data.timed_out));
      end
    end
  end

  // The receiver follows its own stall pattern, or holds off entirely when asked to.
  initial begin
    int unsigned window;
    rx_flow_t    flow;
    window = 0;
    flow   = FLOW_FREE;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (window == 0) begin
          flow   = rx_flow_t'($urandom_range(0, 2));
          window = $urandom_range(16, 96);
        end
        window--;
        case (flow)
          FLOW_FREE:  out_ch.ready <= 1'b1;
          FLOW_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:    out_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_IDX_ENABLE) taps_enabled = value[0];
    else timeout_limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [31:0] now);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{op, now};
    do @(posedge clk); while (!in_ch.ready);
    expect_result(predict_tempo(op, now));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  task automatic offer_item(input logic op, input logic [31:0] now);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(op, now);
  endtask

  task automatic wait_until_idle();
    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    send_item(OP_TAP, 32'd0);
    send_item(OP_TAP, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 32'hFFFF_FFFF);
    wait_until_idle();
  endtask

  task automatic test_estimates();
    logic [31:0] stamps [12];
    // A steady run across the counter wrap, a run with no time between taps,
    // and a run of maximal intervals that drives the estimate to zero.
    stamps = '{32'hFFFF_FC18, 32'd0, 32'd1000, 32'd2000,
               32'd5, 32'd5, 32'd5, 32'd5,
               32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD};
    write_register(CFG_IDX_ENABLE, 16'd1);
    foreach (stamps[i]) send_item(OP_TAP, stamps[i]);
    wait_until_idle();
  endtask

  task automatic test_timeouts();
    send_item(OP_TAP, 32'd100);
    send_item(OP_CHECK, 32'd3100);
    send_item(OP_CHECK, 32'd3101);
    wait_until_idle();
    write_register(CFG_IDX_TIMEOUT, 16'd0);
    send_item(OP_TAP, 32'd7);
    send_item(OP_CHECK, 32'd7);
    send_item(OP_CHECK, 32'd8);
    wait_until_idle();
    write_register(CFG_IDX_TIMEOUT, 16'hFFFF);
    send_item(OP_TAP, 32'hFFFF_0000);
    send_item(OP_CHECK, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 32'd0);
    wait_until_idle();
  endtask

  task automatic test_disabled_mid_run();
    send_item(OP_TAP, 32'd50);
    wait_until_idle();
    write_register(CFG_IDX_ENABLE, 16'd0);
    send_item(OP_TAP, 32'd60);
    send_item(OP_CHECK, 32'd70);
    wait_until_idle();
    write_register(CFG_IDX_ENABLE, 16'd1);
  endtask

  task automatic random_item(input int unsigned tmo);
    int unsigned pick;
    logic        op;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op  = 1'($urandom_range(0, 1));
      now = $urandom;
    end else if (pick < 70) begin
      op       = OP_TAP;
      stamp_ms = stamp_ms + $urandom_range(0, tmo + tmo / 4 + 1);
      now      = stamp_ms;
    end else begin
      op  = OP_CHECK;
      now = stamp_ms + $urandom_range(0, 2 * tmo + 2);
    end
    offer_item(op, now);
  endtask

  task automatic test_random_traffic();
    int unsigned tmo;
    int unsigned items;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       tmo = 1;
        1:       tmo = 65535;
        2:       tmo = $urandom_range(2, 300);
        3:       tmo = $urandom_range(2, 300);
        4:       tmo = $urandom_range(300, 3000);
        default: tmo = $urandom_range(3000, 65534);
      endcase
      wait_until_idle();
      write_register(CFG_IDX_TIMEOUT, tmo[15:0]);
      // The third phase runs with taps switched off and stays short.
      write_register(CFG_IDX_ENABLE, (phase == 2) ? 16'd0 : 16'd1);
      items    = (phase == 2) ? 30 : ITEMS_PER_PHASE;
      stamp_ms = $urandom;
      repeat (items) random_item(tmo);
    end
    wait_until_idle();
    write_register(CFG_IDX_ENABLE, 16'd1);
  endtask

  task automatic test_stall_fill();
    wait_until_idle();
    @(posedge clk);
    hold_off_left = 400;
    repeat (16) begin
      stamp_ms = stamp_ms + $urandom_range(50, 400);
      send_item(($urandom_range(0, 4) == 0) ? OP_CHECK : OP_TAP, stamp_ms);
    end
    wait_until_idle();
  endtask

  initial begin
    int unsigned waited;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.data       = '0;
    taps_enabled     = 1'b0;
    timeout_limit    = 16'd3000;
    run_taps         = 0;
    run_last_tap     = '0;
    run_interval_sum = '0;
    mismatches       = 0;
    hold_off_left    = 0;
    burst_left       = 0;
    stamp_ms         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_after_reset();
    test_estimates();
    test_timeouts();
    test_disabled_mid_run();
    test_random_traffic();
    test_stall_fill();

    pause_sender(1);
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/tte_pkg.sv
design/tte_stream_if.sv
design/tte_serial_div.sv
design/tap_tempo_estimator.sv
bench/tap_tempo_estimator_test.sv
